// ----- rtl/nsc_pkg.sv -----
// Shared types and constants of the NMEA sentence checker.
package nsc_pkg;

  localparam int MAX_LINE = 128;
  localparam int LINE_W   = $clog2(MAX_LINE);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_BAD_SUM  = 2'd2,
    STATUS_VALID    = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    gga_flag;
  } nsc_result_t;

endpackage

// ----- rtl/nsc_stream_if.sv -----
// Valid/ready channel interfaces for received bytes and line status.
interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsc_status_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       gga_flag;

  modport source (output valid, output status, output gga_flag, input ready);
  modport sink (input valid, input status, input gga_flag, output ready);
endinterface

// ----- rtl/nmea_sentence_checker.sv -----
// Top level of the NMEA sentence checker: input register, line tracker, result register.
//
// Takes one received byte per transaction and returns exactly one status per byte, in
// order. A new byte is accepted every cycle while statuses are taken. A byte's status is
// offered once the byte has passed through the input register, where a single pass of
// short logic updates the running line registers, into the result register. The status
// then waits in the result register until it is taken. While a status waits, the
// input register holds one more byte, and after that the input stalls. Status 3
// marks a newline that closed a sentence starting with '$' whose checksum digits after
// '*' match the XOR of the bytes between them, and gga_flag then tells whether "GGA,"
// occurred in it; status 2 marks any other non-empty line, status 1 a byte dropped
// because the line reached 127 bytes, and status 0 everything else.
module nmea_sentence_checker
  import nsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  nsc_byte_if.sink            rx,
  nsc_status_if.source        res
);

  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        res_valid;
  nsc_result_t result_q;
  nsc_result_t result_d;
  logic        advance;
  logic        stage_free;

  // The result register can take a new value when empty or being drained.
  assign advance    = !res_valid || res.ready;
  assign stage_free = !byte_valid || advance;
  assign rx.ready   = stage_free;

  nsc_line_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .en     (byte_valid && advance),
    .data   (byte_q),
    .result (result_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (stage_free) byte_valid <= rx.valid;
      if (advance) res_valid <= byte_valid;
    end
    if (rx.valid && stage_free) byte_q <= rx.rx_byte;
    if (advance && byte_valid) result_q <= result_d;
  end

  assign res.valid    = res_valid;
  assign res.status   = result_q.status;
  assign res.gga_flag = result_q.gga_flag;

endmodule

// ----- rtl/nsc_line_tracker.sv -----
// Running per-line state: length, checksum, hex digits and GGA search.
module nsc_line_tracker
  import nsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  data,
  output nsc_result_t result
);

  logic [LINE_W-1:0] line_count, line_count_next;
  logic              start_ok, start_ok_next;
  logic [7:0]        xor_acc, xor_acc_next;
  logic              star_seen, star_seen_next;
  logic [1:0]        digits_after_star, digits_after_star_next;
  logic [3:0]        first_digit, first_digit_next;
  logic              digits_valid, digits_valid_next;
  logic              text_ended, text_ended_next;
  logic [1:0]        gga_match, gga_match_next;
  logic              gga_seen, gga_seen_next;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    return v;
  endfunction

  logic [4:0] hex;
  logic       sentence_ok;

  assign hex = hex_value(data);
  assign sentence_ok = start_ok && star_seen && (digits_after_star == 2'd2) && digits_valid;

  always_comb begin
    line_count_next        = line_count;
    start_ok_next          = start_ok;
    xor_acc_next           = xor_acc;
    star_seen_next         = star_seen;
    digits_after_star_next = digits_after_star;
    first_digit_next       = first_digit;
    digits_valid_next      = digits_valid;
    text_ended_next        = text_ended;
    gga_match_next         = gga_match;
    gga_seen_next          = gga_seen;
    result.status          = STATUS_NONE;
    result.gga_flag        = 1'b0;

    if (data == CH_CR) begin
      // Carriage returns leave everything untouched.
    end else if (data != CH_LF) begin
      if (line_count >= LINE_W'(MAX_LINE - 1)) begin
        line_count_next        = '0;
        start_ok_next          = 1'b0;
        xor_acc_next           = '0;
        star_seen_next         = 1'b0;
        digits_after_star_next = '0;
        first_digit_next       = '0;
        digits_valid_next      = 1'b1;
        text_ended_next        = 1'b0;
        gga_match_next         = '0;
        gga_seen_next          = 1'b0;
        result.status          = STATUS_TOO_LONG;
      end else begin
        line_count_next = line_count + LINE_W'(1);
        if (!text_ended) begin
          if (data == CH_NUL) begin
            text_ended_next = 1'b1;
          end else begin
            if (gga_match == 2'd3 && data == CH_COMMA) begin
              gga_seen_next  = 1'b1;
              gga_match_next = 2'd0;
            end else if (gga_match == 2'd2 && data == CH_A) begin
              gga_match_next = 2'd3;
            end else if (data == CH_G) begin
              gga_match_next = (gga_match == 2'd1 || gga_match == 2'd2) ? 2'd2 : 2'd1;
            end else begin
              gga_match_next = 2'd0;
            end

            if (line_count == '0) begin
              start_ok_next = (data == CH_DOLLAR);
            end else if (!star_seen) begin
              if (data == CH_STAR) star_seen_next = 1'b1;
              else xor_acc_next = xor_acc ^ data;
            end else if (digits_after_star == 2'd0) begin
              if (hex[4]) digits_valid_next = 1'b0;
              else first_digit_next = hex[3:0];
              digits_after_star_next = 2'd1;
            end else if (digits_after_star == 2'd1) begin
              if (hex[4] || {first_digit, hex[3:0]} != xor_acc) digits_valid_next = 1'b0;
              digits_after_star_next = 2'd2;
            end
          end
        end
      end
    end else if (line_count != '0) begin
      if (sentence_ok) begin
        result.status   = STATUS_VALID;
        result.gga_flag = gga_seen;
      end else begin
        result.status = STATUS_BAD_SUM;
      end
      line_count_next        = '0;
      start_ok_next          = 1'b0;
      xor_acc_next           = '0;
      star_seen_next         = 1'b0;
      digits_after_star_next = '0;
      first_digit_next       = '0;
      digits_valid_next      = 1'b1;
      text_ended_next        = 1'b0;
      gga_match_next         = '0;
      gga_seen_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count        <= '0;
      start_ok          <= 1'b0;
      xor_acc           <= '0;
      star_seen         <= 1'b0;
      digits_after_star <= '0;
      first_digit       <= '0;
      digits_valid      <= 1'b1;
      text_ended        <= 1'b0;
      gga_match         <= '0;
      gga_seen          <= 1'b0;
    end else if (en) begin
      line_count        <= line_count_next;
      start_ok          <= start_ok_next;
      xor_acc           <= xor_acc_next;
      star_seen         <= star_seen_next;
      digits_after_star <= digits_after_star_next;
      first_digit       <= first_digit_next;
      digits_valid      <= digits_valid_next;
      text_ended        <= text_ended_next;
      gga_match         <= gga_match_next;
      gga_seen          <= gga_seen_next;
    end
  end

  // A newline always leaves an empty line behind.
  a_lf_clears: assert property (@(posedge clk) disable iff (rst)
    en && data == CH_LF |=> line_count == '0 && !star_seen && !gga_seen)
    else $error("line state not cleared after newline");

  // Digits are only counted once the star has been seen.
  a_digits_need_star: assert property (@(posedge clk) disable iff (rst)
    digits_after_star != 2'd0 |-> star_seen)
    else $error("checksum digits counted without a star");

  // Any text state implies at least one byte was stored.
  a_text_has_length: assert property (@(posedge clk) disable iff (rst)
    (star_seen || gga_match != 2'd0 || text_ended) |-> line_count != '0)
    else $error("text state set on an empty line");

  // A carriage return must not disturb the line.
  a_cr_holds: assert property (@(posedge clk) disable iff (rst)
    en && data == CH_CR |=> $stable(line_count) && $stable(xor_acc) && $stable(gga_match))
    else $error("carriage return changed line state");

  // The line length never goes beyond MAX_LINE - 1 bytes.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> line_count <= LINE_W'(MAX_LINE - 1))
    else $error("line count beyond limit");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the NMEA sentence checker: directed table, random lines, scoreboard.
module tb_top;
  import nsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    status_t    st;
    logic       gga;
  } stim_row_t;

  localparam int N_DIR = 26;
  localparam int N_RANDOM = 1900;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_AT = 600;
  localparam int HOLD_CYCLES = 200;

  // Bytes just outside the hex digit ranges.
  localparam logic [7:0] NOT_HEX [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

  // Directed lines: empty line, extreme bytes without a dollar sign, a GGA sentence with a
  // lowercase checksum, a star as first byte, an empty valid sentence, a short checksum.
  stim_row_t dir_rows [N_DIR] = '{
    '{CH_CR,     1'b1, STATUS_NONE,    1'b0},
    '{CH_LF,     1'b1, STATUS_NONE,    1'b0},
    '{CH_NUL,    1'b1, STATUS_NONE,    1'b0},
    '{8'hFF,     1'b1, STATUS_NONE,    1'b0},
    '{CH_LF,     1'b1, STATUS_BAD_SUM, 1'b0},
    '{CH_DOLLAR, 1'b0, STATUS_NONE,    1'b0},
    '{CH_G,      1'b0, STATUS_NONE,    1'b0},
    '{CH_G,      1'b0, STATUS_NONE,    1'b0},
    '{CH_A,      1'b0, STATUS_NONE,    1'b0},
    '{CH_COMMA,  1'b0, STATUS_NONE,    1'b0},
    '{CH_STAR,   1'b0, STATUS_NONE,    1'b0},
    '{"6",       1'b0, STATUS_NONE,    1'b0},
    '{"d",       1'b0, STATUS_NONE,    1'b0},
    '{CH_CR,     1'b1, STATUS_NONE,    1'b0},
    '{CH_LF,     1'b1, STATUS_VALID,   1'b1},
    '{CH_STAR,   1'b0, STATUS_NONE,    1'b0},
    '{CH_LF,     1'b1, STATUS_BAD_SUM, 1'b0},
    '{CH_DOLLAR, 1'b0, STATUS_NONE,    1'b0},
    '{CH_STAR,   1'b0, STATUS_NONE,    1'b0},
    '{"0",       1'b0, STATUS_NONE,    1'b0},
    '{"0",       1'b0, STATUS_NONE,    1'b0},
    '{CH_LF,     1'b1, STATUS_VALID,   1'b0},
    '{CH_DOLLAR, 1'b0, STATUS_NONE,    1'b0},
    '{CH_STAR,   1'b0, STATUS_NONE,    1'b0},
    '{"0",       1'b0, STATUS_NONE,    1'b0},
    '{CH_LF,     1'b1, STATUS_BAD_SUM, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  nsc_byte_if   rx_ch ();
  nsc_status_if res_ch ();

  nmea_sentence_checker uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_row_t   stim_q [$];
  nsc_result_t expected_q [$];
  int          acc_idx = 0;
  int          err_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          quiet_tail = 1'b0;

  // Running line state of the predictor.
  logic [LINE_W-1:0] line_len;
  logic              starts_dollar;
  logic [7:0]        running_xor;
  logic              star_hit;
  logic [1:0]        digit_cnt;
  logic [3:0]        hi_nibble;
  logic              sum_ok;
  logic              text_done;
  logic [1:0]        gga_state;
  logic              gga_found;

  function automatic void clear_line_state();
    line_len      = '0;
    starts_dollar = 1'b0;
    running_xor   = 8'h00;
    star_hit      = 1'b0;
    digit_cnt     = 2'd0;
    hi_nibble     = 4'h0;
    sum_ok        = 1'b1;
    text_done     = 1'b0;
    gga_state     = 2'd0;
    gga_found     = 1'b0;
  endfunction

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_code(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic nsc_result_t judge_byte(input logic [7:0] c);
    nsc_result_t r;
    logic [4:0]  h;
    r.status   = STATUS_NONE;
    r.gga_flag = 1'b0;
    if (c != CH_CR && c != CH_LF) begin
      if (int'(line_len) >= MAX_LINE - 1) begin
        clear_line_state();
        r.status = STATUS_TOO_LONG;
      end else begin
        if (!text_done) begin
          if (c == CH_NUL) begin
            text_done = 1'b1;
          end else begin
            if (gga_state == 2'd3 && c == CH_COMMA) begin
              gga_found = 1'b1;
              gga_state = 2'd0;
            end else if (gga_state == 2'd2 && c == CH_A) begin
              gga_state = 2'd3;
            end else if (c == CH_G) begin
              gga_state = (gga_state == 2'd1 || gga_state == 2'd2) ? 2'd2 : 2'd1;
            end else begin
              gga_state = 2'd0;
            end
            if (line_len == 0) begin
              starts_dollar = (c == CH_DOLLAR);
            end else if (!star_hit) begin
              if (c == CH_STAR) star_hit = 1'b1;
              else running_xor ^= c;
            end else if (digit_cnt < 2'd2) begin
              h = hex_code(c);
              if (h[4]) sum_ok = 1'b0;
              else if (digit_cnt == 2'd0) hi_nibble = h[3:0];
              else if ({hi_nibble, h[3:0]} != running_xor) sum_ok = 1'b0;
              digit_cnt++;
            end
          end
        end
        line_len++;
      end
    end else if (c == CH_LF && line_len != 0) begin
      if (starts_dollar && star_hit && digit_cnt == 2'd2 && sum_ok) begin
        r.status   = STATUS_VALID;
        r.gga_flag = gga_found;
      end else begin
        r.status = STATUS_BAD_SUM;
      end
      clear_line_state();
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stim_q.push_back('{b, 1'b0, STATUS_NONE, 1'b0});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  // Printable sentence text, biased toward the letters of the GGA search.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = CH_G;
      1: c = CH_A;
      2: c = CH_COMMA;
      default: c = 8'($urandom_range(32, 126));
    endcase
    if (c == CH_STAR) c = CH_COMMA;
    return c;
  endfunction

  task automatic add_sentence();
    logic [7:0] body [$];
    logic [7:0] sum;
    int         n;
    int         pos;
    int         flaw;
    sum = 8'h00;
    n = $urandom_range(0, 24);
    for (int i = 0; i < n; i++) body.push_back(text_char());
    if ($urandom_range(0, 9) < 4) begin
      pos = $urandom_range(0, n);
      body.insert(pos, CH_COMMA);
      body.insert(pos, CH_A);
      body.insert(pos, CH_G);
      body.insert(pos, CH_G);
    end
    if ($urandom_range(0, 19) == 0) body.insert($urandom_range(0, body.size()), CH_NUL);
    foreach (body[i]) sum ^= body[i];
    flaw = $urandom_range(0, 19);
    if (flaw == 0) sum ^= 8'(1 << $urandom_range(0, 7));
    push_byte(CH_DOLLAR);
    foreach (body[i]) push_byte(body[i]);
    push_byte(CH_STAR);
    if (flaw == 1) push_byte(NOT_HEX[$urandom_range(0, 5)]);
    else push_byte(hex_char(sum[7:4], $urandom_range(0, 1)));
    if (flaw == 2) push_byte(NOT_HEX[$urandom_range(0, 5)]);
    else if (flaw != 3) push_byte(hex_char(sum[3:0], $urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_byte(text_char());
    if ($urandom_range(0, 1)) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic add_random_lines();
    int         pick;
    logic [7:0] b;
    while (stim_q.size() < N_DIR + N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        add_sentence();
      end else if (pick < 80) begin
        // Raw noise over the whole byte range, newlines and returns included.
        repeat ($urandom_range(1, 24)) push_byte(8'($urandom_range(0, 255)));
        push_byte(CH_LF);
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: push_byte(CH_STAR);
          1: push_byte(text_char());
          default: push_byte(CH_DOLLAR);
        endcase
        repeat ($urandom_range(0, 12)) push_byte(text_char());
        if ($urandom_range(0, 1)) begin
          push_byte(CH_STAR);
          push_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
          push_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
        end
        push_byte(CH_LF);
      end else if (pick < 96) begin
        // Lines around the length limit.
        if ($urandom_range(0, 1)) push_byte(CH_DOLLAR);
        repeat ($urandom_range(124, 132)) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_LF || b == CH_CR) b = text_char();
          push_byte(b);
        end
        push_byte(CH_LF);
      end else begin
        if ($urandom_range(0, 1)) push_byte(CH_CR);
        push_byte(CH_LF);
      end
    end
  endtask

  function automatic bit calm_phase();
    return ((acc_idx / 160) % 4) == 3;
  endfunction

  // Scoreboard: predict on each accepted byte, compare each accepted status.
  always @(posedge clk) begin
    nsc_result_t pred;
    nsc_result_t want;
    if (rst === 1'b0) begin
      if (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) begin
        pred = judge_byte(rx_ch.rx_byte);
        if (stim_q[acc_idx].typed) begin
          want.status   = stim_q[acc_idx].st;
          want.gga_flag = stim_q[acc_idx].gga;
        end else begin
          want = pred;
        end
        expected_q.push_back(want);
        acc_idx++;
      end
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transaction, status %0d gga %0d", $time,
                   res_ch.status, res_ch.gga_flag);
        end else begin
          want = expected_q.pop_front();
          if (res_ch.status !== want.status) begin
            err_cnt++;
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, res_ch.status);
          end
          if (res_ch.gga_flag !== want.gga_flag) begin
            err_cnt++;
            $display("%0t: gga_flag mismatch, expected %0d, actual %0d", $time,
                     want.gga_flag, res_ch.gga_flag);
          end
        end
      end
    end
  end

  // Receiver: short random stalls, one long hold-off so the block backs up.
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!hold_done && acc_idx >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!quiet_tail && !calm_phase() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Sender and end of run.
  initial begin
    int gap;
    int wait_cnt;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    clear_line_state();
    foreach (dir_rows[i]) stim_q.push_back(dir_rows[i]);
    add_random_lines();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i >= stim_q.size() - TAIL_ITEMS) quiet_tail = 1'b1;
      gap = 0;
      if (!quiet_tail && !calm_phase() && hold_left == 0 && $urandom_range(0, 5) == 0)
        gap = $urandom_range(1, 4);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rx_ch.valid <= 1'b1;
      rx_ch.rx_byte <= stim_q[i].ch;
      @(posedge clk);
      while (rx_ch.ready !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
    rx_ch.valid <= 1'b0;
    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 4000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected transactions never arrived", $time, expected_q.size());
    end
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
